@@ src/ppt_pkg.sv @@
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants for the proximity pump toggle controller.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int unsigned DIST_W   = 11;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // distance = echo / 58 as (echo * RECIP) >> SHIFT, exact for 16-bit echo
    localparam int unsigned ECHO_SHIFT = 22;
    localparam logic [16:0] ECHO_RECIP = 17'd72316;

    localparam logic [TICK_W-1:0] START_DELAY    = 16'd1000;
    localparam logic [DIST_W-1:0] RESET_DISTANCE = 11'd100;
    localparam logic [DIST_W-1:0] BOOT_DISTANCE  = 11'd135;
    localparam logic [DIST_W-1:0] MAX_DISTANCE   = 11'd1129;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_DWELL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DWELL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE     = 3'd4;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ECHO = 1'b1;

    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_WAIT_ON   = 3'd1,
        PH_DWELL_ON  = 3'd2,
        PH_PAUSE_ON  = 3'd3,
        PH_WAIT_OFF  = 3'd4,
        PH_DWELL_OFF = 3'd5,
        PH_PAUSE_OFF = 3'd6
    } phase_t;

    typedef struct packed {
        logic              func;
        logic [TICK_W-1:0] echo_ticks;
    } in_word_t;

    typedef struct packed {
        logic              pump_on;
        logic [DIST_W-1:0] distance_cm;
        logic [2:0]        phase;
    } out_word_t;

endpackage

@@ src/proximity_pump_toggle_controller_core.sv @@
// ----------------------------------------------------------------------------
// proximity_pump_toggle_controller_core
// Hand-proximity pump toggle: echo widths to distance, dwell timer, 7 phases.
// ----------------------------------------------------------------------------
// Path: an accepted input word is held in the input register, then in the result register.
// Throughput: one word per cycle; input register, one step of logic, result
//   register, so ready only drops when the result register is stalled.
// Reset (rst_n, async low): empty pipeline, phase 0, timer idle, distance 135,
//   pump off, config registers at 5 / 30 / 500 / 500 / 2000.
// ----------------------------------------------------------------------------
module proximity_pump_toggle_controller_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // config write port
    input  logic                                 cfg_wr_en,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input words
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  ppt_pkg::in_word_t                    in_word,
    // result words
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ppt_pkg::out_word_t                   out_word
);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [ppt_pkg::DIST_W-1:0] near_min_reg;
    logic [ppt_pkg::DIST_W-1:0] near_max_reg;
    logic [ppt_pkg::TICK_W-1:0] on_dwell_reg;
    logic [ppt_pkg::TICK_W-1:0] off_dwell_reg;
    logic [ppt_pkg::TICK_W-1:0] pause_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_min_reg  <= 11'd5;
            near_max_reg  <= 11'd30;
            on_dwell_reg  <= 16'd500;
            off_dwell_reg <= 16'd500;
            pause_reg     <= 16'd2000;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ppt_pkg::CFG_NEAR_MIN:  near_min_reg  <= cfg_data[ppt_pkg::DIST_W-1:0];
                ppt_pkg::CFG_NEAR_MAX:  near_max_reg  <= cfg_data[ppt_pkg::DIST_W-1:0];
                ppt_pkg::CFG_ON_DWELL:  on_dwell_reg  <= cfg_data;
                ppt_pkg::CFG_OFF_DWELL: off_dwell_reg <= cfg_data;
                ppt_pkg::CFG_PAUSE:     pause_reg     <= cfg_data;
                default: ; // unmapped index, dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: input register -> step logic -> result register
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    ppt_pkg::in_word_t s1_word_reg;
    logic              out_valid_reg;
    ppt_pkg::out_word_t out_word_reg;
    logic              step_en;   // word in s1 is processed and moves to result

    assign step_en   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || step_en;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_word_reg <= in_word;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    ppt_pkg::phase_t            phase_reg, phase_next;
    logic [ppt_pkg::TICK_W-1:0] dwell_cnt_reg, dwell_cnt_next;
    logic                       dwell_run_reg, dwell_run_next;
    logic [ppt_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic                       pump_reg, pump_next;

    // echo / 58 by reciprocal multiply
    logic [32:0]                echo_prod;
    logic [ppt_pkg::DIST_W-1:0] echo_dist;

    assign echo_prod = 33'(s1_word_reg.echo_ticks) * 33'(ppt_pkg::ECHO_RECIP);
    assign echo_dist = echo_prod[ppt_pkg::ECHO_SHIFT +: ppt_pkg::DIST_W];

    logic                       is_tick;
    logic                       in_win;
    logic [ppt_pkg::TICK_W-1:0] period;
    logic [ppt_pkg::TICK_W-1:0] cnt_inc;     // count after this tick
    logic [ppt_pkg::TICK_W-1:0] cnt_load;    // count after a load attempt
    logic                       load_expired; // load, then check
    logic                       run_expired;  // check only

    assign is_tick = (s1_word_reg.func == ppt_pkg::FUNC_TICK);
    assign in_win  = (dist_reg > near_min_reg) && (dist_reg < near_max_reg);

    // timer advances while running, saturating at all ones
    assign cnt_inc  = (dwell_run_reg && (dwell_cnt_reg != '1)) ?
                      dwell_cnt_reg + 16'd1 : dwell_cnt_reg;
    // load only restarts an idle timer
    assign cnt_load = dwell_run_reg ? cnt_inc : '0;
    assign load_expired = (cnt_load >= period);
    assign run_expired  = dwell_run_reg && (cnt_inc >= period);

    always_comb
    begin
        case (phase_reg)
            ppt_pkg::PH_START:     period = ppt_pkg::START_DELAY;
            ppt_pkg::PH_DWELL_ON:  period = on_dwell_reg;
            ppt_pkg::PH_PAUSE_ON,
            ppt_pkg::PH_PAUSE_OFF: period = pause_reg;
            ppt_pkg::PH_DWELL_OFF: period = off_dwell_reg;
            default:               period = '0;
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_tick)
        begin
            case (phase_reg)
                ppt_pkg::PH_START:
                    if (load_expired) phase_next = ppt_pkg::PH_WAIT_ON;
                ppt_pkg::PH_WAIT_ON:
                    if (in_win) phase_next = ppt_pkg::PH_DWELL_ON;
                ppt_pkg::PH_DWELL_ON:
                    if (run_expired)
                        phase_next = in_win ? ppt_pkg::PH_PAUSE_ON : ppt_pkg::PH_WAIT_ON;
                ppt_pkg::PH_PAUSE_ON:
                    if (load_expired) phase_next = ppt_pkg::PH_WAIT_OFF;
                ppt_pkg::PH_WAIT_OFF:
                    if (in_win) phase_next = ppt_pkg::PH_DWELL_OFF;
                ppt_pkg::PH_DWELL_OFF:
                    if (run_expired)
                        phase_next = in_win ? ppt_pkg::PH_PAUSE_OFF : ppt_pkg::PH_WAIT_OFF;
                ppt_pkg::PH_PAUSE_OFF:
                    if (load_expired) phase_next = ppt_pkg::PH_WAIT_ON;
                default: ;
            endcase
        end
    end

    // timer, distance and pump updates
    always_comb
    begin
        dwell_cnt_next = dwell_cnt_reg;
        dwell_run_next = dwell_run_reg;
        dist_next      = dist_reg;
        pump_next      = pump_reg;
        if (!is_tick)
        begin
            dist_next = echo_dist;
        end
        else
        begin
            dwell_cnt_next = cnt_inc;
            case (phase_reg)
                ppt_pkg::PH_START,
                ppt_pkg::PH_PAUSE_ON,
                ppt_pkg::PH_PAUSE_OFF:
                begin
                    dwell_cnt_next = cnt_load;
                    dwell_run_next = !load_expired;
                end
                ppt_pkg::PH_WAIT_ON,
                ppt_pkg::PH_WAIT_OFF:
                begin
                    if (in_win)
                    begin
                        dwell_cnt_next = cnt_load;
                        dwell_run_next = 1'b1;
                    end
                end
                ppt_pkg::PH_DWELL_ON:
                begin
                    if (run_expired)
                    begin
                        dwell_run_next = 1'b0;
                        // distance resets on both pass and fail of the on-check
                        dist_next      = ppt_pkg::RESET_DISTANCE;
                        if (in_win) pump_next = 1'b1;
                    end
                end
                ppt_pkg::PH_DWELL_OFF:
                begin
                    if (run_expired)
                    begin
                        dwell_run_next = 1'b0;
                        if (in_win)
                        begin
                            pump_next = 1'b0;
                            dist_next = ppt_pkg::RESET_DISTANCE;
                        end
                    end
                end
                default: ; // only the timer advances
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ppt_pkg::PH_START;
            dwell_cnt_reg <= '0;
            dwell_run_reg <= 1'b0;
            dist_reg      <= ppt_pkg::BOOT_DISTANCE;
            pump_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            dwell_cnt_reg <= dwell_cnt_next;
            dwell_run_reg <= dwell_run_next;
            dist_reg      <= dist_next;
            pump_reg      <= pump_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_word_reg.pump_on     <= pump_next;
            out_word_reg.distance_cm <= dist_next;
            out_word_reg.phase       <= 3'(phase_next);
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // pump runs exactly from the on-switch to the off-switch
    a_pump_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pump_reg == (phase_reg == ppt_pkg::PH_PAUSE_ON ||
                     phase_reg == ppt_pkg::PH_WAIT_OFF ||
                     phase_reg == ppt_pkg::PH_DWELL_OFF))
        else $error("pump state does not match phase");

    // waiting phases are only entered with the timer stopped
    a_wait_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ppt_pkg::PH_WAIT_ON || phase_reg == ppt_pkg::PH_WAIT_OFF)
        |-> !dwell_run_reg)
        else $error("dwell timer running in a wait phase");

    // stored distance never exceeds 1129, the largest quotient of a 16-bit echo
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        dist_reg <= ppt_pkg::MAX_DISTANCE)
        else $error("stored distance out of range");

    // a stalled result holds the step, not a dropped word
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && s1_valid_reg) |=> s1_valid_reg && out_valid_reg)
        else $error("word lost while result stalled");

endmodule
